>>> hw/rtl/hid_report_to_pad_buttons_assert.svh
// Assertion macros shared by the pad button converter.
`ifndef HID_REPORT_TO_PAD_BUTTONS_ASSERT_SVH
`define HID_REPORT_TO_PAD_BUTTONS_ASSERT_SVH
// Assert that a condition implies a consequence on the same edge.
`define HRP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence on the next edge.
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Types and constants shared by the report to pad button converter.
// ----------------------------------------------------------------------------
`default_nettype none
package hrp_pkg;
  localparam logic [1:0] OpByte   = 2'd0;
  localparam logic [1:0] OpLast   = 2'd1;
  localparam logic [1:0] OpDetach = 2'd2;

  // The highest byte ever read is the upper half of a button word at offset 15.
  localparam int unsigned StoreBytes = 17;

  localparam logic [2:0] LayoutReport6 = 3'd0;
  localparam logic [2:0] Layout8Bit    = 3'd1;
  localparam logic [2:0] LayoutId16    = 3'd2;
  localparam logic [2:0] LayoutAt2     = 3'd3;
  localparam logic [2:0] LayoutEntry   = 3'd4;
  localparam logic [2:0] LayoutEntryId = 3'd5;
  localparam logic [2:0] LayoutFallbk  = 3'd6;

  localparam logic [4:0] RegLowPress    = 5'd0;
  localparam logic [4:0] RegLowRelease  = 5'd1;
  localparam logic [4:0] RegHighPress   = 5'd2;
  localparam logic [4:0] RegHighRelease = 5'd3;
  localparam logic [4:0] RegSwap        = 5'd4;

  localparam logic [16:0] MidLow  = 17'd16000;
  localparam logic [16:0] MidHigh = 17'd48000;

  localparam logic [3:0] SearchOff [7] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd12, 4'd13};

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pad_buttons;
    logic [15:0] axis_value;
    logic        up;
    logic        down;
    logic [2:0]  layout_code;
  } result_t;
endpackage
`default_nettype wire

>>> hw/rtl/hrp_front.sv
// ----------------------------------------------------------------------------
// hrp_front
// Accepts input items, classifies them and feeds a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none
module hrp_front import hrp_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  output logic       full_o,
  input  wire        op_i,
  input  wire  [7:0] data_byte_i,
  input  wire        last_byte_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  wire        cmd_take_i
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;
  cmd_t       cmd_in;

  assign full_o      = cnt_q == 2'd2;
  assign wr          = push_i && !full_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign rd          = cmd_take_i && cmd_valid_o;
  assign cmd_o       = mem_q[rp_q];

  always_comb begin
    cmd_in.data = data_byte_i;
    if (op_i) begin
      cmd_in.op = OpDetach;
    end else if (last_byte_i) begin
      cmd_in.op = OpLast;
    end else begin
      cmd_in.op = OpByte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/hrp_back.sv
// ----------------------------------------------------------------------------
// hrp_back
// Stores report bytes and evaluates a finished report through a sequence of states.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_report_to_pad_buttons_assert.svh"
module hrp_back import hrp_pkg::*; #(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_take_o,
  input  wire  [15:0] low_press_i,
  input  wire  [15:0] low_release_i,
  input  wire  [15:0] high_press_i,
  input  wire  [15:0] high_release_i,
  input  wire         swap_i,
  output logic        res_valid_o,
  output result_t     res_o,
  input  wire         res_take_i
);
  localparam int unsigned CntW = $clog2(REPORT_BYTES + 1);

  typedef enum logic [2:0] {
    StIdle, StGuess, StButtons, StSearch, StAxis, StOut
  } state_e;

  // Only the first seventeen bytes are ever read; later bytes are counted only.
  logic [7:0]      store_q [StoreBytes];
  logic [CntW-1:0] cnt_q, len_q;
  state_e          state_q;
  logic            known_q, wide_q, hat_q, signed_q, r6_q, upf_q, dnf_q;
  logic [3:0]      axoff_q, btoff_q, hatoff_q;
  logic [2:0]      sel_q;
  logic [2:0]      si_q;
  logic [31:0]     btn_q;
  logic [15:0]     x_q;
  result_t         res_q;
  logic            res_valid_q;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  // Only a last byte needs the result register free; other commands pass a waiting result.
  assign cmd_take_o  = cmd_valid_i && state_q == StIdle &&
                       (!res_valid_q || cmd_i.op != OpLast);

  function automatic logic [15:0] w16(input logic [7:0] s [StoreBytes], input logic [3:0] o);
    logic [4:0] o0, o1;
    o0 = {1'b0, o};
    o1 = o0 + 5'd1;
    return {s[o1], s[o0]};
  endfunction

  function automatic logic mid(input logic [15:0] v);
    return {1'b0, v} >= MidLow && {1'b0, v} <= MidHigh;
  endfunction

  // Length compare: offset plus k strictly below the report length.
  function automatic logic fits(input logic [3:0] o, input logic [2:0] k,
                                input logic [CntW-1:0] l);
    return (CntW'(o) + CntW'(k)) < l;
  endfunction

  logic [7:0]  b0, b1;
  logic [15:0] sv;
  logic [3:0]  soff;
  logic [3:0]  h;
  logic        upc, dnc, upo, dno, nu, nd;
  logic [31:0] btn;
  logic [15:0] pad;
  logic [15:0] ax;

  assign b0   = store_q[0];
  assign b1   = store_q[1];
  assign soff = SearchOff[si_q];
  assign sv   = w16(store_q, soff);
  assign btn  = btn_q;
  assign h    = store_q[{1'b0, hatoff_q}][3:0];

  always_comb begin
    if (wide_q) begin
      ax = fits(axoff_q, 3'd1, len_q) ?
           (w16(store_q, axoff_q) ^ {signed_q, 15'd0}) : 16'h7FFF;
    end else begin
      ax = fits(axoff_q, 3'd0, len_q) ?
           {store_q[{1'b0, axoff_q}], store_q[{1'b0, axoff_q}]} : 16'h7FFF;
    end
  end

  always_comb begin
    nu = upf_q;
    nd = dnf_q;
    if (!nu) begin
      if (x_q < low_press_i) begin nu = 1'b1; nd = 1'b0; end
    end else if (x_q > low_release_i) begin
      nu = 1'b0;
    end
    if (!nd) begin
      if (x_q > high_press_i) begin nd = 1'b1; nu = 1'b0; end
    end else if (x_q < high_release_i) begin
      nd = 1'b0;
    end
    upc = swap_i ? nd : nu;
    dnc = swap_i ? nu : nd;
    if (hat_q && fits(hatoff_q, 3'd0, len_q)) begin
      if (h == 4'd0 || h == 4'd1 || h == 4'd7) upc = 1'b1;
      if (h == 4'd3 || h == 4'd4 || h == 4'd5) dnc = 1'b1;
    end
    upo = upc | btn[10];
    dno = dnc | btn[11];
    pad = 16'hFFFF;
    if (btn[0]) pad[15] = 1'b0;
    if (btn[1]) pad[10] = 1'b0;
    if (btn[2]) pad[14] = 1'b0;
    if (btn[3]) pad[11] = 1'b0;
    if (btn[4]) pad[13] = 1'b0;
    if (btn[5]) pad[9]  = 1'b0;
    if (btn[6]) pad[7]  = 1'b0;
    if (btn[7]) begin
      if (r6_q) pad[3] = 1'b0; else pad[0] = 1'b0;
    end
    if (btn[9] || btn[8]) begin
      if (r6_q) pad[0] = 1'b0; else pad[3] = 1'b0;
    end
    if (upo) pad[4] = 1'b0;
    if (dno) pad[6] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_i.op != OpDetach &&
        cnt_q < CntW'(StoreBytes)) begin
      store_q[cnt_q[4:0]] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      len_q       <= '0;
      known_q     <= 1'b0;
      wide_q      <= 1'b1;
      hat_q       <= 1'b0;
      signed_q    <= 1'b0;
      r6_q        <= 1'b0;
      upf_q       <= 1'b0;
      dnf_q       <= 1'b0;
      axoff_q     <= 4'd2;
      btoff_q     <= 4'd0;
      hatoff_q    <= 4'd4;
      sel_q       <= LayoutFallbk;
      si_q        <= '0;
      btn_q       <= '0;
      x_q         <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_valid_q && res_take_i) res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (cmd_take_o) begin
            case (cmd_i.op)
              OpDetach: begin
                known_q  <= 1'b0;
                signed_q <= 1'b0;
                r6_q     <= 1'b0;
                upf_q    <= 1'b0;
                dnf_q    <= 1'b0;
                cnt_q    <= '0;
              end
              OpLast: begin
                len_q   <= (cnt_q < CntW'(REPORT_BYTES)) ? cnt_q + CntW'(1) : cnt_q;
                cnt_q   <= '0;
                state_q <= known_q ? StButtons : StGuess;
              end
              default: begin
                if (cnt_q < CntW'(REPORT_BYTES)) cnt_q <= cnt_q + CntW'(1);
              end
            endcase
          end
        end
        StGuess: begin
          state_q <= StButtons;
          if (len_q >= CntW'(7) && b0 == 8'h06) begin
            axoff_q <= 4'd5; btoff_q <= 4'd1; wide_q <= 1'b1; signed_q <= 1'b1;
            hat_q <= len_q >= CntW'(16); hatoff_q <= 4'd15; r6_q <= 1'b1;
            known_q <= 1'b1; sel_q <= LayoutReport6;
          end else if (len_q >= CntW'(6) && b0 >= 8'd64 && b0 <= 8'd192 &&
                       b1 >= 8'd64 && b1 <= 8'd192) begin
            axoff_q <= 4'd0; wide_q <= 1'b0; hat_q <= 1'b1; hatoff_q <= 4'd4;
            btoff_q <= (len_q >= CntW'(7)) ? 4'd5 : 4'd4;
            known_q <= 1'b1; sel_q <= Layout8Bit;
          end else if (len_q >= CntW'(5) && b0 > 8'd0 && b0 < 8'd8 &&
                       mid(w16(store_q, 4'd3))) begin
            axoff_q <= 4'd3; btoff_q <= 4'd1; wide_q <= 1'b1; hat_q <= 1'b0;
            known_q <= 1'b1; sel_q <= LayoutId16;
          end else if (len_q >= CntW'(4) && mid(w16(store_q, 4'd2))) begin
            axoff_q <= 4'd2; btoff_q <= 4'd0; wide_q <= 1'b1; hat_q <= 1'b0;
            known_q <= 1'b1; sel_q <= LayoutAt2;
          end else if (len_q >= CntW'(14) && mid(w16(store_q, 4'd0))) begin
            axoff_q <= 4'd0; btoff_q <= 4'd12; wide_q <= 1'b1; hat_q <= 1'b0;
            known_q <= 1'b1; sel_q <= LayoutEntry;
          end else if (len_q >= CntW'(14) && mid(w16(store_q, 4'd1))) begin
            axoff_q <= 4'd1; btoff_q <= 4'd13; wide_q <= 1'b1; hat_q <= 1'b0;
            known_q <= 1'b1; sel_q <= LayoutEntryId;
          end else begin
            if (b0 > 8'd0 && b0 < 8'd8) begin
              axoff_q <= 4'd3; btoff_q <= 4'd1;
            end else begin
              axoff_q <= 4'd2; btoff_q <= 4'd0;
            end
            wide_q <= 1'b1; hat_q <= 1'b0; sel_q <= LayoutFallbk;
          end
        end
        StButtons: begin
          btn_q <= '0;
          si_q  <= '0;
          if (fits(btoff_q, 3'd1, len_q)) begin
            btn_q[15:0] <= w16(store_q, btoff_q);
            if (fits(btoff_q, 3'd3, len_q)) begin
              btn_q[31:16] <= w16(store_q, btoff_q + 4'd2);
            end
          end
          state_q <= StSearch;
        end
        StSearch: begin
          // One candidate offset per cycle while the word read so far is zero.
          if (btn_q != 32'd0 || si_q == 3'd7) begin
            state_q <= StAxis;
          end else begin
            si_q <= si_q + 3'd1;
            if (fits(soff, 3'd1, len_q) && soff != axoff_q &&
                !(hat_q && soff == hatoff_q) && sv != 16'd0 &&
                sv[7:0] != 8'h80 && sv[7:0] != 8'h7F) begin
              btn_q   <= {16'd0, sv};
              btoff_q <= soff;
              state_q <= StAxis;
            end
          end
        end
        StAxis: begin
          x_q     <= ax;
          state_q <= StOut;
        end
        StOut: begin
          upf_q <= nu;
          dnf_q <= nd;
          res_q <= '{pad_buttons: pad, axis_value: x_q, up: upo, down: dno,
                     layout_code: sel_q};
          res_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `HRP_ASSERT_NEXT(a_out_valid, state_q == StOut, res_valid_q, "result not posted")
  `HRP_ASSERT_IMPL(a_no_take_busy, cmd_take_o,
                   state_q == StIdle && (!res_valid_q || cmd_i.op != OpLast),
                   "command taken while busy")
  `HRP_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CntW'(REPORT_BYTES), "byte count overflow")
endmodule
`default_nettype wire

>>> hw/rtl/hid_report_to_pad_buttons.sv
// A report byte passes a two-entry queue to the back end; a last byte then runs the
// layout guess if the layout is unknown, the button read, the offset search, the axis
// read and the result register. The queue takes one item per cycle while not full and
// is drained at one byte per cycle while the back end is idle; a last byte holds the
// back end until its result is posted. Reset is asynchronous and active low; it
// restores register defaults and forgets the layout. The report store has no reset.
// ----------------------------------------------------------------------------
// hid_report_to_pad_buttons
// Converts a controller report into an active-low pad button word.
// ----------------------------------------------------------------------------
`default_nettype none
module hid_report_to_pad_buttons import hrp_pkg::*; #(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire         op_i,
  input  wire  [7:0]  data_byte_i,
  input  wire         last_byte_i,
  output logic        empty,
  input  wire         pop,
  output logic [15:0] pad_buttons_o,
  output logic [15:0] axis_value_o,
  output logic        up_o,
  output logic        down_o,
  output logic [2:0]  layout_code_o,
  input  wire         cfg_we_i,
  input  wire  [4:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);
  logic        cmd_valid, cmd_take, res_valid;
  cmd_t        cmd;
  result_t     res;
  logic [15:0] lp_q, lr_q, hp_q, hr_q;
  logic        swap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= 16'd16384; lr_q <= 16'd24576; hp_q <= 16'd49152; hr_q <= 16'd40960;
      swap_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLowPress:    lp_q   <= cfg_data_i;
        RegLowRelease:  lr_q   <= cfg_data_i;
        RegHighPress:   hp_q   <= cfg_data_i;
        RegHighRelease: hr_q   <= cfg_data_i;
        RegSwap:        swap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  hrp_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .op_i, .data_byte_i,
    .last_byte_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  hrp_back #(.REPORT_BYTES(REPORT_BYTES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .low_press_i(lp_q), .low_release_i(lr_q), .high_press_i(hp_q),
    .high_release_i(hr_q), .swap_i(swap_q), .res_valid_o(res_valid), .res_o(res),
    .res_take_i(pop)
  );

  assign empty         = !res_valid;
  assign pad_buttons_o = res.pad_buttons;
  assign axis_value_o  = res.axis_value;
  assign up_o          = res.up;
  assign down_o        = res.down;
  assign layout_code_o = res.layout_code;
endmodule
`default_nettype wire

>>> verif/tb_hid_report_to_pad_buttons.sv
// ----------------------------------------------------------------------------
// tb_hid_report_to_pad_buttons
// Sends HID reports byte by byte to the pad button converter, with random
// gaps and stalls on both queue sides, and compares every pad result with an
// in-bench model of layout learning, button search and turntable hysteresis.
// ----------------------------------------------------------------------------
module tb_hid_report_to_pad_buttons;
  import hrp_pkg::*;

  localparam bit          OpReportByte = 1'b0;
  localparam bit          OpDetached   = 1'b1;
  localparam int unsigned RptBytes     = 64;
  localparam int unsigned MaxWait      = 17;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned RandomItems  = 800;

  localparam int PadSelect = 0, PadStart = 3, PadUp = 4, PadDown = 6, PadLeft = 7;
  localparam int PadR2 = 9, PadL1 = 10, PadR1 = 11, PadCircle = 13, PadCross = 14;
  localparam int PadSquare = 15;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        op_i = OpReportByte;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] pad_buttons_o;
  logic [15:0] axis_value_o;
  logic        up_o;
  logic        down_o;
  logic [2:0]  layout_code_o;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_idx_i = RegLowPress;
  logic [15:0] cfg_data_i = '0;

  hid_report_to_pad_buttons dut (
    .clk_i, .rst_ni, .push, .full, .op_i, .data_byte_i, .last_byte_i,
    .empty, .pop, .pad_buttons_o, .axis_value_o, .up_o, .down_o, .layout_code_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Model state.
  logic [15:0] lvl_low_press, lvl_low_release, lvl_high_press, lvl_high_release;
  bit          dir_swap;
  logic [7:0]  rpt [RptBytes];
  int unsigned rpt_len;
  bit          lay_known, ax_wide, hat_on, ax_signed, rpt6;
  int unsigned ax_off, btn_off, hat_off;
  logic [2:0]  lay_code;
  bit          up_flag, down_flag;

  result_t     pending_pads[$];
  bit          failed = 1'b0;
  int unsigned items_sent = 0;

  function automatic int unsigned word_at(int unsigned off);
    return {16'h0, rpt[off + 1], rpt[off]};
  endfunction

  function automatic bit in_mid(int unsigned v);
    return v >= 16000 && v <= 48000;
  endfunction

  function automatic void learn_wide(int unsigned ax, int unsigned bt, logic [2:0] code);
    ax_off = ax;
    btn_off = bt;
    ax_wide = 1'b1;
    hat_on = 1'b0;
    lay_known = 1'b1;
    lay_code = code;
  endfunction

  function automatic void guess_layout(int unsigned len);
    if (len >= 7 && rpt[0] == 8'h06) begin
      ax_off = 5;
      btn_off = 1;
      ax_wide = 1'b1;
      ax_signed = 1'b1;
      hat_on = len >= 16;
      hat_off = 15;
      rpt6 = 1'b1;
      lay_known = 1'b1;
      lay_code = LayoutReport6;
    end else if (len >= 6 && rpt[0] >= 64 && rpt[0] <= 192 &&
                 rpt[1] >= 64 && rpt[1] <= 192) begin
      ax_off = 0;
      ax_wide = 1'b0;
      hat_on = 1'b1;
      hat_off = 4;
      btn_off = (len >= 7) ? 5 : 4;
      lay_known = 1'b1;
      lay_code = Layout8Bit;
    end else if (len >= 5 && rpt[0] > 0 && rpt[0] < 8 && in_mid(word_at(3))) begin
      learn_wide(3, 1, LayoutId16);
    end else if (len >= 4 && in_mid(word_at(2))) begin
      learn_wide(2, 0, LayoutAt2);
    end else if (len >= 14 && in_mid(word_at(0))) begin
      learn_wide(0, 12, LayoutEntry);
    end else if (len >= 14 && in_mid(word_at(1))) begin
      learn_wide(1, 13, LayoutEntryId);
    end else begin
      // The fallback leaves the layout unknown so the next report is guessed again.
      if (rpt[0] > 0 && rpt[0] < 8) begin
        ax_off = 3;
        btn_off = 1;
      end else begin
        ax_off = 2;
        btn_off = 0;
      end
      ax_wide = 1'b1;
      hat_on = 1'b0;
      lay_code = LayoutFallbk;
    end
  endfunction

  function automatic int unsigned buttons_of(int unsigned len);
    int unsigned w;
    int unsigned cand [7];
    int unsigned v;
    w = 0;
    cand = '{0, 1, 2, 4, 5, 12, 13};
    if (btn_off + 1 < len) begin
      w = word_at(btn_off);
      if (btn_off + 3 < len) w |= word_at(btn_off + 2) << 16;
    end
    if (w != 0) return w;
    foreach (cand[i]) begin
      if (cand[i] + 1 >= len || cand[i] == ax_off) continue;
      if (hat_on && cand[i] == hat_off) continue;
      v = word_at(cand[i]);
      if (v != 0 && v[7:0] != 8'h80 && v[7:0] != 8'h7F) begin
        btn_off = cand[i];
        return v;
      end
    end
    return 0;
  endfunction

  function automatic int unsigned axis_of(int unsigned len);
    if (ax_wide) begin
      if (ax_off + 1 < len) return ax_signed ? (word_at(ax_off) ^ 32'h8000) : word_at(ax_off);
      return 32'h7FFF;
    end
    if (ax_off < len) return rpt[ax_off] * 257;
    return 32'h7FFF;
  endfunction

  function automatic void predict_item(bit op, logic [7:0] data, bit last);
    int unsigned len, btn, x, h;
    bit up, down;
    logic [15:0] pad;
    result_t r;
    if (op == OpDetached) begin
      lay_known = 1'b0;
      ax_signed = 1'b0;
      rpt6 = 1'b0;
      up_flag = 1'b0;
      down_flag = 1'b0;
      rpt_len = 0;
      return;
    end
    if (rpt_len < RptBytes) begin
      rpt[rpt_len] = data;
      rpt_len++;
    end
    if (!last) return;
    len = rpt_len;
    rpt_len = 0;
    if (!lay_known) guess_layout(len);
    btn = buttons_of(len);
    x = axis_of(len);

    if (!up_flag) begin
      if (x < lvl_low_press) begin
        up_flag = 1'b1;
        down_flag = 1'b0;
      end
    end else if (x > lvl_low_release) begin
      up_flag = 1'b0;
    end
    if (!down_flag) begin
      if (x > lvl_high_press) begin
        down_flag = 1'b1;
        up_flag = 1'b0;
      end
    end else if (x < lvl_high_release) begin
      down_flag = 1'b0;
    end
    up = dir_swap ? down_flag : up_flag;
    down = dir_swap ? up_flag : down_flag;

    if (hat_on && hat_off < len) begin
      h = rpt[hat_off] & 4'hF;
      if (h == 0 || h == 1 || h == 7) up = 1'b1;
      if (h == 3 || h == 4 || h == 5) down = 1'b1;
    end
    if (btn[10]) up = 1'b1;
    if (btn[11]) down = 1'b1;

    pad = 16'hFFFF;
    if (btn[0]) pad[PadSquare] = 1'b0;
    if (btn[1]) pad[PadL1] = 1'b0;
    if (btn[2]) pad[PadCross] = 1'b0;
    if (btn[3]) pad[PadR1] = 1'b0;
    if (btn[4]) pad[PadCircle] = 1'b0;
    if (btn[5]) pad[PadR2] = 1'b0;
    if (btn[6]) pad[PadLeft] = 1'b0;
    if (btn[7]) pad[rpt6 ? PadStart : PadSelect] = 1'b0;
    if (btn[9:8] != 0) pad[rpt6 ? PadSelect : PadStart] = 1'b0;
    if (up) pad[PadUp] = 1'b0;
    if (down) pad[PadDown] = 1'b0;

    r.pad_buttons = pad;
    r.axis_value = x[15:0];
    r.up = up;
    r.down = down;
    r.layout_code = lay_code;
    pending_pads.push_back(r);
  endfunction

  function automatic int unsigned draw_wait();
    // Roughly a third of the transfers go without any idle cycle.
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(bit op, logic [7:0] data, bit last);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    data_byte_i <= data;
    last_byte_i <= last;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    predict_item(op, data, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_report(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(OpReportByte, bytes[i], i == bytes.size() - 1);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_pads.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [4:0] idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      RegLowPress:    lvl_low_press = value;
      RegLowRelease:  lvl_low_release = value;
      RegHighPress:   lvl_high_press = value;
      RegHighRelease: lvl_high_release = value;
      RegSwap:        dir_swap = value[0];
      default: ;
    endcase
  endtask

  task automatic set_levels(logic [15:0] lp, logic [15:0] lr, logic [15:0] hp,
                            logic [15:0] hr, bit swap);
    drain_results();
    write_reg(RegLowPress, lp);
    write_reg(RegLowRelease, lr);
    write_reg(RegHighPress, hp);
    write_reg(RegHighRelease, hr);
    write_reg(RegSwap, {15'h0, swap});
  endtask

  // Builds a report whose shape matches one of the known layouts or none.
  function automatic void make_report(ref logic [7:0] bytes[$]);
    int unsigned len, kind;
    logic [15:0] mid;
    bytes.delete();
    kind = $urandom_range(0, 8);
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 20);
    mid = 16'($urandom_range(16000, 48000));
    for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0)
      for (int i = 0; i < len; i++) if (i > 1) bytes[i] = 8'h00;
    case (kind)
      0: bytes[0] = 8'h06;
      1: begin
        bytes[0] = 8'($urandom_range(64, 192));
        if (len > 1) bytes[1] = 8'($urandom_range(64, 192));
      end
      2: begin
        bytes[0] = 8'($urandom_range(1, 7));
        if (len > 4) {bytes[4], bytes[3]} = mid;
      end
      3: if (len > 3) {bytes[3], bytes[2]} = mid;
      4: if (len > 1) {bytes[1], bytes[0]} = mid;
      5: if (len > 2) {bytes[2], bytes[1]} = mid;
      default: ;
    endcase
  endfunction

  task automatic test_directed();
    logic [7:0] b[$];
    // Report id 6 with hat switch, then detach so the next report is guessed.
    b = '{8'h06, 8'hFF, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03};
    send_report(b);
    send_item(OpDetached, 8'h00, 1'b0);
    // Eight-bit axes with a hat.
    b = '{8'hC0, 8'h40, 8'h00, 8'h00, 8'h07, 8'h01, 8'h0C};
    send_report(b);
    // Detach while a report is partly collected.
    send_item(OpReportByte, 8'hAA, 1'b0);
    send_item(OpDetached, 8'hFF, 1'b1);
    // Short report of one byte: fallback layout with no readable fields.
    send_item(OpReportByte, 8'h00, 1'b1);
    // Report id with 16-bit axis.
    b = '{8'h01, 8'h00, 8'h00, 8'h80, 8'h3E};
    send_report(b);
    send_item(OpDetached, 8'h00, 1'b0);
    // Low button half zero, upper half nonzero, so the candidate search is skipped; axis at two.
    b = '{8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h34, 8'h12};
    send_report(b);
    send_item(OpDetached, 8'h00, 1'b0);
    // Overlong report whose last mark falls on a dropped byte.
    b.delete();
    for (int i = 0; i < 70; i++) b.push_back(i == 0 ? 8'h80 : 8'h00);
    b[1] = 8'h7D;
    send_report(b);
    send_item(OpDetached, 8'h00, 1'b0);
    // Fallback, then the same report again: detection must rerun.
    b = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
    send_report(b);
    send_report(b);
  endtask

  task automatic test_levels();
    logic [7:0] b[$];
    logic [15:0] lv [3];
    lv = '{16'h0000, 16'hFFFF, 16'h8000};
    foreach (lv[k]) begin
      set_levels(lv[k], ~lv[k], ~lv[k], lv[k], k[0]);
      send_item(OpDetached, 8'h00, 1'b0);
      for (int j = 0; j < 4; j++) begin
        b = '{8'h00, 8'h00, 8'h00, 8'h00};
        {b[3], b[2]} = (j[0]) ? 16'hFFFF : 16'h0000;
        send_report(b);
      end
    end
    set_levels(16384, 24576, 49152, 40960, 1'b0);
  endtask

  task automatic test_random();
    logic [7:0] b[$];
    int unsigned start, next_cfg;
    start = items_sent;
    next_cfg = start + 150;
    while (items_sent - start < RandomItems) begin
      if (items_sent >= next_cfg) begin
        // Every so often the sender holds off until all results are in.
        set_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom_range(0, 1)));
        next_cfg = items_sent + 150;
      end
      if ($urandom_range(0, 2) == 0)
        send_item(OpDetached, 8'($urandom), 1'($urandom_range(0, 1)));
      make_report(b);
      if ($urandom_range(0, 19) == 0) b = b[0:b.size() / 2];
      send_report(b);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      failed = 1'b1;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    int unsigned stall;
    result_t want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_wait();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (!empty) break;
      end
      if (pending_pads.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result transfer with none expected, actual pad %0h", $time,
                 pad_buttons_o);
      end else begin
        want = pending_pads.pop_front();
        check_field("pad_buttons", want.pad_buttons, pad_buttons_o);
        check_field("axis_value", want.axis_value, axis_value_o);
        check_field("up", want.up, up_o);
        check_field("down", want.down, down_o);
        check_field("layout_code", want.layout_code, layout_code_o);
      end
    end
  end

  initial begin
    #30000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    lvl_low_press = 16384;
    lvl_low_release = 24576;
    lvl_high_press = 49152;
    lvl_high_release = 40960;
    dir_swap = 1'b0;
    rpt_len = 0;
    lay_known = 1'b0;
    ax_off = 2;
    btn_off = 0;
    hat_off = 4;
    ax_wide = 1'b1;
    hat_on = 1'b0;
    ax_signed = 1'b0;
    rpt6 = 1'b0;
    up_flag = 1'b0;
    down_flag = 1'b0;
    lay_code = LayoutFallbk;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_levels();
    test_random();
    drain_results();
    if (!failed && pending_pads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
